// ----- design/bw1d_pkg.sv -----
// Package for the 1-D blend weight block: request/result structs, command,
// status and sequencer state codes, Q1.15 constants. No dependencies.
package bw1d_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_EVAL   = 2'd3
  } bw1d_cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_EMPTY     = 2'd3
  } bw1d_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SHIFT,
    S_RM_SHIFT,
    S_EV_LAST,
    S_EV_SCAN,
    S_EV_DIV,
    S_OUT
  } bw1d_state_t;

  typedef struct packed {
    bw1d_cmd_t          command;
    logic signed [31:0] position_or_value;
    logic [3:0]         entry_index;
  } bw1d_in_t;

  typedef struct packed {
    logic [3:0]   lower_index;
    logic [3:0]   upper_index;
    logic [15:0]  lower_weight;
    logic [15:0]  upper_weight;
    logic [4:0]   entry_count;
    bw1d_status_t status;
  } bw1d_out_t;

  localparam logic [15:0] Q15_ONE     = 16'd32768;
  localparam logic [15:0] Q15_HALF    = 16'd16384;
  // 0.0001 in Q16.16, truncated
  localparam logic [31:0] NARROW_SPAN = 32'd6;
  // quotient bits produced by the serial divider before rounding
  localparam int          FRAC_BITS   = 15;

endpackage

// ----- design/bw1d_div.sv -----
// Serial fractional divider: round(num * 2^15 / den) for num < den, one
// quotient bit per cycle over a shared compare/subtract. Uses bw1d_pkg.
module bw1d_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [15:0] quot
);
  import bw1d_pkg::*;

  localparam int CNTW = $clog2(FRAC_BITS);

  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          den_r, den_nxt;
  logic [FRAC_BITS-1:0] q_r, q_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;

  logic [32:0] shifted;
  logic [32:0] diff;
  logic        take;
  logic [31:0] half_up;
  logic        round_up;

  always_comb begin
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {1'b0, den_r};
    take     = shifted >= {1'b0, den_r};
    half_up  = den_r - (den_r >> 1);
    round_up = rem_r >= half_up;

    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;

    if (start) begin
      rem_nxt = num;
      den_nxt = den;
      q_nxt   = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = take ? diff[31:0] : shifted[31:0];
      q_nxt   = {q_r[FRAC_BITS-2:0], take};
      cnt_nxt = cnt_r + CNTW'(1);
      if (cnt_r == CNTW'(FRAC_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = 16'({1'b0, q_r}) + 16'(round_up);

endmodule

// ----- design/blend_weights_1d.sv -----
// Blend weight block: sorted breakpoint table with clear/add/remove/evaluate.
// Sequencing: clear, rejected and one-step requests go straight to the output state;
// add shifts larger entries up one by one; remove shifts later entries down; evaluate
// reads the last entry, scans the table through the single table read port, then may wait on the 15-step divider.
// One request at a time; the next is accepted the cycle after the result is registered.
// Synchronous active-low reset empties the table count; table contents stay as-is.
module blend_weights_1d #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bw1d_pkg::bw1d_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bw1d_pkg::bw1d_out_t out_data
);
  import bw1d_pkg::*;

  // table address width and count width (count must reach MAX_ENTRIES)
  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  // compare width wide enough for the 4-bit request index and count + 2
  localparam int CMPW = (CW > 4) ? CW + 1 : 5;

  // breakpoint table: one write port, one registered read port
  logic signed [31:0] mem [MAX_ENTRIES];
  logic               mem_we;
  logic [IW-1:0]      mem_wa;
  logic signed [31:0] mem_wd;
  logic [IW-1:0]      rd_addr;
  logic signed [31:0] rdata_r;

  bw1d_state_t        state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic               last_eq_r, last_eq_nxt;
  bw1d_out_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  bw1d_out_t          out_data_r, out_data_nxt;

  logic [CMPW-1:0]    idx_ext;
  logic [CMPW-1:0]    cnt_ext;
  logic [32:0]        span_w;
  logic [32:0]        num_w;

  logic               div_start;
  logic               div_done;
  logic [15:0]        div_quot;

  bw1d_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_w[31:0]),
    .den   (span_w[31:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[rd_addr];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    idx_ext = CMPW'(in_data.entry_index);
    cnt_ext = CMPW'(count_r);
    // bracketing span and offset; both positive when an interior bracket is found
    span_w  = {rdata_r[31], rdata_r} - {prev_r[31], prev_r};
    num_w   = {val_r[31], val_r} - {prev_r[31], prev_r};

    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    val_nxt       = val_r;
    prev_nxt      = prev_r;
    last_eq_nxt   = last_eq_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    // drop the result once the consumer takes it
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_wa        = IW'(ptr_r);
    mem_wd        = val_r;
    rd_addr       = '0;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = in_data.position_or_value;
          res_nxt = '0;
          res_nxt.status = STAT_OK;
          state_nxt = S_OUT;
          unique case (in_data.command)
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_ADD: begin
              if (count_r == CW'(MAX_ENTRIES)) begin
                res_nxt.status = STAT_FULL;
              end else if (count_r == '0) begin
                mem_we    = 1'b1;
                mem_wa    = '0;
                mem_wd    = in_data.position_or_value;
                count_nxt = CW'(1);
              end else begin
                // walk down from the top, moving larger entries up by one
                rd_addr   = IW'(count_r - CW'(1));
                ptr_nxt   = count_r;
                state_nxt = S_ADD_SHIFT;
              end
            end
            CMD_REMOVE: begin
              if (idx_ext >= cnt_ext) begin
                res_nxt.status = STAT_BAD_INDEX;
              end else if (idx_ext + CMPW'(1) < cnt_ext) begin
                rd_addr   = IW'(idx_ext + CMPW'(1));
                ptr_nxt   = CW'(in_data.entry_index);
                state_nxt = S_RM_SHIFT;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_EVAL: begin
              if (count_r == '0) begin
                res_nxt.status = STAT_EMPTY;
              end else if (count_r == CW'(1)) begin
                res_nxt.lower_weight = Q15_ONE;
              end else begin
                // fetch the last entry first to catch the clamp-high case
                rd_addr   = IW'(count_r - CW'(1));
                state_nxt = S_EV_LAST;
              end
            end
            default: ;
          endcase
        end
      end

      S_ADD_SHIFT: begin
        // rdata_r holds entry ptr-1
        mem_we = 1'b1;
        mem_wa = IW'(ptr_r);
        if (ptr_r != '0 && rdata_r > val_r) begin
          mem_wd  = rdata_r;
          ptr_nxt = ptr_r - CW'(1);
          rd_addr = IW'(ptr_r - CW'(2));
        end else begin
          mem_wd    = val_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_OUT;
        end
      end

      S_RM_SHIFT: begin
        // rdata_r holds entry ptr+1; move it down
        mem_we  = 1'b1;
        mem_wa  = IW'(ptr_r);
        mem_wd  = rdata_r;
        ptr_nxt = ptr_r + CW'(1);
        rd_addr = IW'(ptr_r + CW'(2));
        if (!(CMPW'(ptr_r) + CMPW'(2) < cnt_ext)) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_OUT;
        end
      end

      S_EV_LAST: begin
        last_eq_nxt = (rdata_r == val_r);
        if (rdata_r < val_r) begin
          res_nxt.lower_index  = 4'(count_r - CW'(1));
          res_nxt.upper_index  = 4'(count_r - CW'(1));
          res_nxt.lower_weight = Q15_ONE;
          state_nxt            = S_OUT;
        end else begin
          rd_addr   = '0;
          ptr_nxt   = '0;
          state_nxt = S_EV_SCAN;
        end
      end

      S_EV_SCAN: begin
        // rdata_r holds entry ptr; the last entry is known to be at or above the value
        if (rdata_r >= val_r) begin
          state_nxt = S_OUT;
          if (ptr_r == '0) begin
            res_nxt.lower_weight = Q15_ONE;
          end else if (rdata_r == val_r) begin
            // an exact match takes that entry's index; equal to the last entry clamps to the last index
            res_nxt.lower_index  = last_eq_r ? 4'(count_r - CW'(1)) : 4'(ptr_r);
            res_nxt.upper_index  = last_eq_r ? 4'(count_r - CW'(1)) : 4'(ptr_r);
            res_nxt.lower_weight = Q15_ONE;
          end else begin
            res_nxt.lower_index = 4'(ptr_r - CW'(1));
            res_nxt.upper_index = 4'(ptr_r);
            if (span_w[31:0] <= NARROW_SPAN) begin
              res_nxt.lower_weight = Q15_HALF;
              res_nxt.upper_weight = Q15_HALF;
            end else begin
              div_start = 1'b1;
              state_nxt = S_EV_DIV;
            end
          end
        end else begin
          prev_nxt = rdata_r;
          ptr_nxt  = ptr_r + CW'(1);
          rd_addr  = IW'(ptr_r + CW'(1));
        end
      end

      S_EV_DIV: begin
        if (div_done) begin
          res_nxt.upper_weight = div_quot;
          res_nxt.lower_weight = Q15_ONE - div_quot;
          state_nxt            = S_OUT;
        end
      end

      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt             = res_r;
          out_data_nxt.entry_count = 5'(count_r);
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    val_r      <= val_nxt;
    prev_r     <= prev_nxt;
    last_eq_r  <= last_eq_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
